@@ rtl/core/wsf_pkg.sv @@
package wsf_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int CHANNEL_BITS_DEF = 16;

  // Configuration port geometry
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SMOOTH_EN    = 2'd2;

  // Register reset values and limits
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = 13'd4096;

  // Result buffering ahead of the output channel
  localparam int OUT_FIFO_DEPTH = 8;

  // 3x3 neighborhood: row-major, index 4 is the center
  localparam int NBR_CNT = 9;

  // Source of a copied (not smoothed) result
  typedef logic [1:0] src_sel_t;
  localparam src_sel_t SRC_CENTER = 2'd0;
  localparam src_sel_t SRC_EDGE   = 2'd1;
  localparam src_sel_t SRC_NEWER  = 2'd2;

  // Control that travels alongside a result through the kernel
  typedef struct packed {
    logic valid;
    logic inner;
    logic last;
  } side_t;

endpackage

@@ rtl/core/wsf_ram.sv @@
module wsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/wsf_kernel.sv @@
module wsf_kernel #(
  parameter int CHANNEL_BITS = wsf_pkg::CHANNEL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wsf_pkg::side_t              side_i,
  input  logic [3*CHANNEL_BITS-1:0]   nbr_i [wsf_pkg::NBR_CNT],
  input  logic [3*CHANNEL_BITS-1:0]   copy_i,
  output wsf_pkg::side_t              side_o,
  output logic [3*CHANNEL_BITS-1:0]   px_o
);

  import wsf_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int PW = 3 * CB;
  // 45 * max channel + rounding bias stays below 2^(CB+6)
  localparam int SW = CB + 6;
  localparam int K  = SW + 1;
  localparam int QW = 2 * SW - K;
  localparam logic [SW-1:0] RECIP      = SW'((64'd1 << K) / 64'd45);
  localparam logic [SW-1:0] ROUND_BIAS = SW'(22);
  localparam logic [SW-1:0] DIVISOR    = SW'(45);

  logic [SW-1:0]   sum_a_nxt [3];
  logic [SW-1:0]   sum_a_r   [3];
  logic [PW-1:0]   copy_a_r;
  side_t           side_a_r;
  logic [2*SW-1:0] prod_b_r  [3];
  logic [SW-1:0]   sum_b_r   [3];
  logic [PW-1:0]   copy_b_r;
  side_t           side_b_r;

  // Weighted sum: corners + 4 * edges + 25 * center + half divisor
  always_comb begin
    logic [SW-1:0] corner_sum;
    logic [SW-1:0] edg_sum;
    logic [SW-1:0] ctr;
    for (int ch = 0; ch < 3; ch++) begin
      corner_sum = SW'(nbr_i[0][ch*CB +: CB]) + SW'(nbr_i[2][ch*CB +: CB]) +
                   SW'(nbr_i[6][ch*CB +: CB]) + SW'(nbr_i[8][ch*CB +: CB]);
      edg_sum    = SW'(nbr_i[1][ch*CB +: CB]) + SW'(nbr_i[3][ch*CB +: CB]) +
                   SW'(nbr_i[5][ch*CB +: CB]) + SW'(nbr_i[7][ch*CB +: CB]);
      ctr        = SW'(nbr_i[4][ch*CB +: CB]);
      sum_a_nxt[ch] = corner_sum + (edg_sum << 2) + (ctr << 4) + (ctr << 3) + ctr +
                      ROUND_BIAS;
    end
  end

  // Sum stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_a_r <= '0;
    end else begin
      side_a_r <= side_i;
    end
    copy_a_r <= copy_i;
    for (int ch = 0; ch < 3; ch++) begin
      sum_a_r[ch] <= sum_a_nxt[ch];
    end
  end

  // Reciprocal multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_b_r <= '0;
    end else begin
      side_b_r <= side_a_r;
    end
    copy_b_r <= copy_a_r;
    for (int ch = 0; ch < 3; ch++) begin
      prod_b_r[ch] <= (2*SW)'(sum_a_r[ch]) * (2*SW)'(RECIP);
      sum_b_r[ch]  <= sum_a_r[ch];
    end
  end

  // Estimate is low by at most one: correct with one compare, then pick
  always_comb begin
    logic [QW-1:0] q_est;
    logic [SW-1:0] q0;
    logic [SW-1:0] rem;
    logic [SW-1:0] quo;
    for (int ch = 0; ch < 3; ch++) begin
      q_est = prod_b_r[ch][2*SW-1:K];
      q0    = SW'(q_est);
      rem   = sum_b_r[ch] - ((q0 << 5) + (q0 << 3) + (q0 << 2) + q0);
      quo   = q0 + SW'(rem >= DIVISOR);
      px_o[ch*CB +: CB] = side_b_r.inner ? quo[CB-1:0] : copy_b_r[ch*CB +: CB];
    end
  end

  assign side_o = side_b_r;

endmodule

@@ rtl/core/wsf_out_fifo.sv @@
module wsf_out_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wsf_pkg::OUT_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid & pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth and update the fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/weighted_3x3_smoothing_filter.sv @@
// Weighted 3x3 smoothing filter for an RGB pixel stream in raster order.
// Input channel (in_*): one transaction per pixel; in_tuser = 0 carries a
// pixel, in_tuser = 1 is a flush tick without data. After the last pixel of a
// frame, flush ticks (or further pixels, whose data are dropped) release the
// outputs still held back, one per transaction.
// Output channel (out_*): one transaction per result pixel; out_tlast marks
// the final pixel of the frame. Interior pixels are smoothed when enabled,
// border pixels are copied.
// Configuration (cfg_*): write image width, height and smoothing enable while
// the block is idle; a width or height write restarts the frame.
// Throughput: one input transaction per clock while in_tready is high. The row
// memory holds both stored rows of a column in one entry, read and written back
// once per pixel. A result released by an input transaction passes the memory
// stage, the sum stage and the reciprocal multiply stage into the output FIFO
// and can leave the cycle after it is written. A frame's first result is
// released by pixel width + 2. Stall: the output FIFO holds 8 results;
// in_tready drops while 8 released results are not yet delivered.
// Reset: counters clear, width = 640, height = 480, smoothing off. The row
// memory is not cleared; its contents are only used after being written.
module weighted_3x3_smoothing_filter #(
  parameter int MAX_WIDTH    = wsf_pkg::MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = wsf_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // in_tdata: red_in, green_in, blue_in (from bit 0 up), zero padding
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]      in_tdata,
  // in_tuser: kind
  input  logic [0:0]                               in_tuser,
  // out_tdata: red_out, green_out, blue_out (from bit 0 up), zero padding
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]      out_tdata,
  output logic                                     out_tlast,
  input  logic                                     cfg_we,
  input  logic [wsf_pkg::CFG_ADDR_W-1:0]           cfg_addr,
  input  logic [wsf_pkg::CFG_DATA_W-1:0]           cfg_wdata
);

  import wsf_pkg::*;

  localparam int PW  = 3 * CHANNEL_BITS;
  localparam int TDW = ((PW + 7) / 8) * 8;
  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW  = (AW + 1 > WIDTH_REG_W) ? AW + 1 : WIDTH_REG_W;
  localparam int RW  = HEIGHT_REG_W;
  localparam int FCW = $clog2(OUT_FIFO_DEPTH + 1);

  // Configuration registers
  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic                    smooth_r;
  logic                    geom_wr;

  // Position counters
  logic [AW-1:0] in_col_r,  in_col_nxt;
  logic [RW-1:0] in_row_r,  in_row_nxt;
  logic [AW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;
  logic [FCW-1:0] credit_r, credit_nxt;

  // Accept-stage decode
  logic [CW-1:0] eff_w, width_ext, w_m1, in_col_ext, out_col_ext;
  logic [RW-1:0] eff_h, h_m1;
  logic          in_acc, is_pix, row_ge1, row_ge2, col_ge1, col_ge2;
  logic          have_pix, flush_hit, have, out_last, inner, edge_upd;
  src_sel_t      src;
  logic [AW-1:0] ram_raddr;

  // Memory stage
  logic          s1_pix_r, s1_have_r, s1_inner_r, s1_last_r, s1_edge_upd_r;
  src_sel_t      s1_src_r;
  logic [AW-1:0] s1_col_r;
  logic [PW-1:0] s1_px_r;
  logic          fwd_hit_r;
  logic [2*PW-1:0] fwd_data_r;
  logic [2*PW-1:0] ram_rdata, ram_wdata, row_entry;
  logic            ram_we;
  logic [PW-1:0]   top_px, mid_px, copy_px, edge_r;
  logic [PW-1:0]   win_r [6];
  logic [PW-1:0]   nbr [NBR_CNT];

  side_t           k_side_in, k_side_out;
  logic [PW-1:0]   k_px_out;
  logic [PW:0]     fifo_q;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      smooth_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[HEIGHT_REG_W-1:0];
        REG_SMOOTH_EN:    smooth_r <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  assign geom_wr = cfg_we && (cfg_addr == REG_IMAGE_WIDTH || cfg_addr == REG_IMAGE_HEIGHT);

  // Clamp geometry to the supported range
  assign width_ext = CW'(width_r);
  assign eff_w = (width_r == '0) ? CW'(1) :
                 (width_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : width_ext;
  assign eff_h = (height_r == '0) ? RW'(1) :
                 (height_r > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_r;
  assign w_m1  = eff_w - CW'(1);
  assign h_m1  = eff_h - RW'(1);
  assign in_col_ext  = CW'(in_col_r);
  assign out_col_ext = CW'(out_col_r);

  // Decode the transaction at the input
  assign in_tready = (credit_r < FCW'(OUT_FIFO_DEPTH));
  assign in_acc    = in_tvalid & in_tready;
  assign is_pix    = !in_tuser[0] && (in_row_r < eff_h);
  assign row_ge1   = (in_row_r != '0);
  assign row_ge2   = (in_row_r >= RW'(2));
  assign col_ge1   = (in_col_r != '0);
  assign col_ge2   = (in_col_r >= AW'(2));
  assign have_pix  = is_pix && ((row_ge1 && col_ge1) || (row_ge2 && !col_ge1));
  assign flush_hit = !is_pix && (in_row_r >= eff_h) && (out_row_r < eff_h);
  assign have      = have_pix | flush_hit;
  assign out_last  = (out_row_r == h_m1) && (out_col_ext == w_m1);
  assign inner     = is_pix && smooth_r && row_ge2 && col_ge2;
  assign edge_upd  = (in_col_ext == w_m1);
  assign ram_raddr = is_pix ? in_col_r : out_col_r;

  always_comb begin
    if (is_pix) begin
      src = col_ge1 ? SRC_CENTER : SRC_EDGE;
    end else begin
      src = (out_row_r == h_m1) ? SRC_NEWER : SRC_EDGE;
    end
  end

  // Advance input and output positions; restart on frame end or geometry write
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (geom_wr) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (in_acc) begin
      if (is_pix) begin
        if (in_col_ext + CW'(1) >= eff_w) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + RW'(1);
        end else begin
          in_col_nxt = in_col_r + AW'(1);
        end
      end
      if (have) begin
        if (out_last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_ext + CW'(1) == eff_w) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + RW'(1);
        end else begin
          out_col_nxt = out_col_r + AW'(1);
        end
      end
    end
  end

  // Count released results not yet delivered
  always_comb begin
    case ({in_acc && have, out_tvalid && out_tready})
      2'b10:   credit_nxt = credit_r + FCW'(1);
      2'b01:   credit_nxt = credit_r - FCW'(1);
      default: credit_nxt = credit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      credit_r  <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      credit_r  <= credit_nxt;
    end
  end

  // Launch the memory stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pix_r  <= 1'b0;
      s1_have_r <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      s1_pix_r  <= in_acc && is_pix;
      s1_have_r <= in_acc && have;
      fwd_hit_r <= in_acc && ram_we && (s1_col_r == ram_raddr);
    end
    s1_inner_r    <= inner;
    s1_last_r     <= out_last;
    s1_src_r      <= src;
    s1_edge_upd_r <= edge_upd;
    s1_col_r      <= in_col_r;
    s1_px_r       <= in_tdata[PW-1:0];
    fwd_data_r    <= ram_wdata;
  end

  // Row memory: entry holds {older row, newer row} of one column
  wsf_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Take the entry written last cycle when the read hit the same column
  assign row_entry = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign top_px    = row_entry[2*PW-1:PW];
  assign mid_px    = row_entry[PW-1:0];

  // Write back: newer row moves to older, the new pixel becomes newer
  assign ram_we    = s1_pix_r;
  assign ram_wdata = {mid_px, s1_px_r};

  // Shift the window and keep a copy of the newer stored row's last column
  always_ff @(posedge clk) begin
    if (s1_pix_r) begin
      win_r[3] <= win_r[0];
      win_r[4] <= win_r[1];
      win_r[5] <= win_r[2];
      win_r[0] <= top_px;
      win_r[1] <= mid_px;
      win_r[2] <= s1_px_r;
      if (s1_edge_upd_r) begin
        edge_r <= mid_px;
      end
    end
  end

  // Neighborhood, row-major around the center
  assign nbr[0] = win_r[3];
  assign nbr[1] = win_r[0];
  assign nbr[2] = top_px;
  assign nbr[3] = win_r[4];
  assign nbr[4] = win_r[1];
  assign nbr[5] = mid_px;
  assign nbr[6] = win_r[5];
  assign nbr[7] = win_r[2];
  assign nbr[8] = s1_px_r;

  // Pick the copied pixel
  always_comb begin
    case (s1_src_r)
      SRC_CENTER: copy_px = win_r[1];
      SRC_EDGE:   copy_px = edge_r;
      SRC_NEWER:  copy_px = mid_px;
      default:    copy_px = win_r[1];
    endcase
  end

  always_comb begin
    k_side_in.valid = s1_have_r;
    k_side_in.inner = s1_inner_r;
    k_side_in.last  = s1_last_r;
  end

  wsf_kernel #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_kernel (
    .clk    (clk),
    .rst_n  (rst_n),
    .side_i (k_side_in),
    .nbr_i  (nbr),
    .copy_i (copy_px),
    .side_o (k_side_out),
    .px_o   (k_px_out)
  );

  wsf_out_fifo #(
    .WIDTH (PW + 1),
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (k_side_out.valid),
    .push_data ({k_side_out.last, k_px_out}),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (fifo_q)
  );

  assign out_tdata = TDW'(fifo_q[PW-1:0]);
  assign out_tlast = fifo_q[PW];

  // Released results never exceed the FIFO room
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= FCW'(OUT_FIFO_DEPTH))
    else $error("result credit count above FIFO depth");

  // Forwarding only when last cycle wrote the column now being read
  a_fwd_match: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> ($past(ram_we) && ($past(s1_col_r) == $past(ram_raddr))))
    else $error("row forwarding without a matching write");

  // Column counters stay inside the active width
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_col_ext < eff_w) && (out_col_ext < eff_w))
    else $error("column counter outside image width");

  // A result leaving the kernel was counted at the input
  a_kernel_credit: assert property (@(posedge clk) disable iff (!rst_n)
    k_side_out.valid |-> (credit_r != '0))
    else $error("kernel result without credit");

endmodule
